// ----- src/mcpc_pkg.sv -----
// Shared types and constants for the MIDI clock position counter.
package mcpc_pkg;

    // Transport machine codes
    typedef enum logic [1:0] {
        TR_PAUSED   = 2'd0,
        TR_STARTING = 2'd1,
        TR_STARTED  = 2'd2
    } transport_t;

    // Event opcodes; code 7 is undefined and does nothing
    localparam logic [2:0] OP_CLOCK     = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_CONTINUE  = 3'd3;
    localparam logic [2:0] OP_INT_START = 3'd4;
    localparam logic [2:0] OP_INT_STOP  = 3'd5;
    localparam logic [2:0] OP_TOGGLE    = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_A     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_B     = 2'd2;

    // Forwarded transport bytes
    localparam logic [7:0] BYTE_NONE     = 8'h00;
    localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
    localparam logic [7:0] BYTE_START    = 8'hFA;
    localparam logic [7:0] BYTE_STOP     = 8'hFC;
    localparam logic [7:0] BYTE_CONTINUE = 8'hFB;

    // Tick grouping: six ticks per 16th, 32nd advances at the half
    localparam logic [2:0] SIXTH_LAST = 3'd6;
    localparam logic [2:0] SIXTH_HALF = 3'd3;
    localparam logic [2:0] COUNT_WRAP = 3'd5;

    // Tempo measurement: 150000 * 16 divided by the stamp difference
    localparam int unsigned TEMPO_W = 22;
    localparam int unsigned STAMP_W = 16;
    localparam logic [TEMPO_W-1:0] TEMPO_DIVIDEND = 22'd2400000;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET    = 22'd1920;
    localparam int unsigned DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(TEMPO_W - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;    // take the input word
        logic exec;       // apply the event to the state
        logic div_start;  // launch the tempo division
        logic out_load;   // load the result register
    } mcpc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic need_div;   // the event under work measures tempo
        logic div_busy;
        logic div_done;   // last quotient bit this cycle
    } mcpc_status_t;

endpackage

// ----- src/mcpc_div.sv -----
// Serial restoring divider: fixed tempo dividend over a 16-bit difference.
module mcpc_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [mcpc_pkg::STAMP_W-1:0]        divisor,
    output logic                                busy,
    output logic                                done,
    output logic [mcpc_pkg::TEMPO_W-1:0]        quotient
);

    logic [mcpc_pkg::STAMP_W-1:0]   rem_reg, rem_next;
    logic [mcpc_pkg::TEMPO_W-1:0]   quo_reg, quo_next;
    logic [mcpc_pkg::STAMP_W-1:0]   dvs_reg;
    logic [mcpc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic [mcpc_pkg::STAMP_W:0]     trial;
    logic [mcpc_pkg::STAMP_W:0]     diff;
    logic                           fits;

    // One quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, quo_reg[mcpc_pkg::TEMPO_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[mcpc_pkg::STAMP_W-1:0] : trial[mcpc_pkg::STAMP_W-1:0];
        quo_next = {quo_reg[mcpc_pkg::TEMPO_W-2:0], fits};
        cnt_next = cnt_reg + 1'b1;
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == mcpc_pkg::DIV_LAST_STEP) begin
            busy_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            if (start) begin
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Operands
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= mcpc_pkg::TEMPO_DIVIDEND;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == mcpc_pkg::DIV_LAST_STEP);
    assign quotient = quo_next;

endmodule

// ----- src/mcpc_datapath.sv -----
// Datapath: transport state, position counters, tempo and result register.
module mcpc_datapath #(
    parameter int unsigned BAR_LIMIT = 100
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mcpc_pkg::mcpc_cmd_t         cmd,
    output mcpc_pkg::mcpc_status_t      status,
    input  logic                        cfg_wr_en,
    input  logic [mcpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                        cfg_data,
    input  logic [2:0]                  s_opcode,
    input  logic [15:0]                 s_timestamp,
    output logic [7:0]                  m_forward_byte,
    output logic [1:0]                  m_forward_mask,
    output logic [18:0]                 m_pos_192,
    output logic [18:0]                 m_pos_96,
    output logic [16:0]                 m_pos_32,
    output logic [15:0]                 m_pos_16,
    output logic [2:0]                  m_step_in_beat,
    output logic [2:0]                  m_beat_in_bar,
    output logic [6:0]                  m_bar_number,
    output logic [1:0]                  m_transport,
    output logic                        m_beat_led,
    output logic [21:0]                 m_tempo_q4
);

    // Configuration
    logic internal_mode_reg, fwd_a_reg, fwd_b_reg;

    // Captured word
    logic [2:0]  op_reg;
    logic [15:0] stamp_reg;

    // Architectural state
    mcpc_pkg::transport_t transport_reg, transport_next;
    logic [18:0] c192_reg, c192_next, c96_reg, c96_next;
    logic [16:0] c32_reg, c32_next;
    logic [15:0] c16_reg, c16_next;
    logic [2:0]  sixth_reg, sixth_next, step_reg, step_next, beat_reg, beat_next;
    logic [6:0]  bar_reg, bar_next;
    logic [2:0]  free_sixth_reg, free_sixth_next;
    logic [15:0] last_stamp_reg, last_stamp_next;
    logic [21:0] tempo_reg;
    logic        led_reg, led_next;
    logic [7:0]  fbyte_reg, fbyte_next;
    logic [1:0]  fmask_reg, fmask_next;

    // Divider hookup
    logic [15:0] div_divisor;
    logic        div_busy, div_done;
    logic [21:0] div_quotient;

    logic        is_tick;
    logic [2:0]  fs_inc;
    logic        need_div;

    // Tempo measurement trigger and stamp difference
    always_comb begin
        logic [15:0] d;
        is_tick  = (op_reg == mcpc_pkg::OP_CLOCK) || (op_reg == mcpc_pkg::OP_CONTINUE);
        fs_inc   = free_sixth_reg + 3'd1;
        need_div = is_tick && (fs_inc == mcpc_pkg::SIXTH_LAST);
        d = stamp_reg - last_stamp_reg;
        // the timer wrap is taken as 0xFFFF, one short of the full range
        if (stamp_reg < last_stamp_reg) begin
            d = d - 16'd1;
        end
        if (d == 16'd0) begin
            d = 16'd1;
        end
        div_divisor = d;
    end

    // Event update
    always_comb begin
        mcpc_pkg::transport_t tick_state;
        logic [2:0] sp;
        logic [7:0] bar_w;
        logic [7:0] fb;
        logic [1:0] mk;

        transport_next  = transport_reg;
        c192_next       = c192_reg;
        c96_next        = c96_reg;
        c32_next        = c32_reg;
        c16_next        = c16_reg;
        sixth_next      = sixth_reg;
        step_next       = step_reg;
        beat_next       = beat_reg;
        bar_next        = bar_reg;
        free_sixth_next = free_sixth_reg;
        last_stamp_next = last_stamp_reg;
        led_next        = led_reg;
        fb              = mcpc_pkg::BYTE_NONE;
        tick_state      = transport_reg;
        sp              = sixth_reg;
        bar_w           = {1'b0, bar_reg};

        unique case (op_reg)
            mcpc_pkg::OP_CLOCK: begin
                fb = mcpc_pkg::BYTE_CLOCK;
            end
            mcpc_pkg::OP_START: begin
                fb = mcpc_pkg::BYTE_START;
                transport_next = mcpc_pkg::TR_STARTING;
            end
            mcpc_pkg::OP_STOP: begin
                fb = mcpc_pkg::BYTE_STOP;
                transport_next = mcpc_pkg::TR_PAUSED;
            end
            mcpc_pkg::OP_CONTINUE: begin
                fb = mcpc_pkg::BYTE_CONTINUE;
                tick_state = mcpc_pkg::TR_STARTING;
            end
            mcpc_pkg::OP_INT_START: begin
                if (internal_mode_reg) begin
                    fb = mcpc_pkg::BYTE_START;
                    transport_next = mcpc_pkg::TR_STARTED;
                end
            end
            mcpc_pkg::OP_INT_STOP: begin
                led_next = 1'b0;
                if (internal_mode_reg) begin
                    fb = mcpc_pkg::BYTE_STOP;
                    transport_next = mcpc_pkg::TR_PAUSED;
                end
            end
            mcpc_pkg::OP_TOGGLE: begin
                if (internal_mode_reg) begin
                    if (transport_reg == mcpc_pkg::TR_PAUSED) begin
                        fb = mcpc_pkg::BYTE_START;
                        transport_next = mcpc_pkg::TR_STARTED;
                    end else begin
                        fb = mcpc_pkg::BYTE_STOP;
                        led_next = 1'b0;
                        transport_next = mcpc_pkg::TR_PAUSED;
                    end
                end
            end
            default: begin
            end
        endcase

        // Any start clears the positions
        if (fb == mcpc_pkg::BYTE_START) begin
            c192_next  = '0;
            c96_next   = '0;
            c32_next   = '0;
            c16_next   = '0;
            sixth_next = '0;
            step_next  = 3'd1;
            beat_next  = 3'd1;
            bar_next   = 7'd1;
        end

        // Tick: free-running sixth and counter cascade
        if (is_tick) begin
            free_sixth_next = need_div ? 3'd0 : fs_inc;
            if (need_div) begin
                last_stamp_next = stamp_reg;
            end
            if (tick_state == mcpc_pkg::TR_STARTING) begin
                transport_next = mcpc_pkg::TR_STARTED;
            end else if (tick_state == mcpc_pkg::TR_STARTED) begin
                c96_next  = c96_reg + 19'd1;
                c192_next = c192_reg + 19'd1;
                sp = sixth_reg + 3'd1;
                if (sp == mcpc_pkg::SIXTH_LAST) begin
                    step_next = step_reg + 3'd1;
                    sp = 3'd0;
                    c16_next = c16_reg + 16'd1;
                    c32_next = c32_reg + 17'd1;
                    if (c16_next == 16'd0) begin
                        c32_next  = '0;
                        c96_next  = '0;
                        c192_next = '0;
                    end
                end else if (sp == mcpc_pkg::SIXTH_HALF) begin
                    c32_next = c32_reg + 17'd1;
                end
                sixth_next = sp;
                if (step_next == mcpc_pkg::COUNT_WRAP) begin
                    step_next = 3'd1;
                    beat_next = beat_reg + 3'd1;
                end
                if (beat_next == mcpc_pkg::COUNT_WRAP) begin
                    beat_next = 3'd1;
                    bar_w = bar_w + 8'd1;
                end
                if (bar_w > 8'(BAR_LIMIT)) begin
                    bar_w = 8'd1;
                end
                bar_next = bar_w[6:0];
            end
            if (op_reg == mcpc_pkg::OP_CLOCK) begin
                led_next = (step_next == 3'd1) && (transport_next == mcpc_pkg::TR_STARTED);
            end
        end

        // Forward byte only when some port listens
        mk = {fwd_b_reg, fwd_a_reg};
        if (fb == mcpc_pkg::BYTE_NONE || mk == 2'd0) begin
            fb = mcpc_pkg::BYTE_NONE;
            mk = 2'd0;
        end
        fbyte_next = fb;
        fmask_next = mk;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            internal_mode_reg <= 1'b0;
            fwd_a_reg         <= 1'b0;
            fwd_b_reg         <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_index == mcpc_pkg::CFG_INTERNAL_MODE) internal_mode_reg <= cfg_data;
            if (cfg_index == mcpc_pkg::CFG_FORWARD_A)     fwd_a_reg         <= cfg_data;
            if (cfg_index == mcpc_pkg::CFG_FORWARD_B)     fwd_b_reg         <= cfg_data;
        end
    end

    // Input word capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_opcode;
            stamp_reg <= s_timestamp;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transport_reg  <= mcpc_pkg::TR_PAUSED;
            c192_reg       <= '0;
            c96_reg        <= '0;
            c32_reg        <= '0;
            c16_reg        <= '0;
            sixth_reg      <= '0;
            step_reg       <= 3'd1;
            beat_reg       <= 3'd1;
            bar_reg        <= 7'd1;
            free_sixth_reg <= '0;
            last_stamp_reg <= '0;
            led_reg        <= 1'b0;
            tempo_reg      <= mcpc_pkg::TEMPO_RESET;
        end else begin
            if (cmd.exec) begin
                transport_reg  <= transport_next;
                c192_reg       <= c192_next;
                c96_reg        <= c96_next;
                c32_reg        <= c32_next;
                c16_reg        <= c16_next;
                sixth_reg      <= sixth_next;
                step_reg       <= step_next;
                beat_reg       <= beat_next;
                bar_reg        <= bar_next;
                free_sixth_reg <= free_sixth_next;
                last_stamp_reg <= last_stamp_next;
                led_reg        <= led_next;
            end
            if (div_done) begin
                tempo_reg <= div_quotient;
            end
        end
    end

    // Forward byte held until the result is loaded
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            fbyte_reg <= fbyte_next;
            fmask_reg <= fmask_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_forward_byte <= fbyte_reg;
            m_forward_mask <= fmask_reg;
            m_pos_192      <= c192_reg;
            m_pos_96       <= c96_reg;
            m_pos_32       <= c32_reg;
            m_pos_16       <= c16_reg;
            m_step_in_beat <= step_reg;
            m_beat_in_bar  <= beat_reg;
            m_bar_number   <= bar_reg;
            m_transport    <= transport_reg;
            m_beat_led     <= led_reg;
            m_tempo_q4     <= tempo_reg;
        end
    end

    mcpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign status.need_div = need_div;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

endmodule

// ----- src/mcpc_ctrl.sv -----
// Controller: sequences capture, update, tempo division and result hand-off.
module mcpc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  mcpc_pkg::mcpc_status_t  status,
    output mcpc_pkg::mcpc_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DIV  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // Commands and next state
    always_comb begin
        cmd.capture   = (state_reg == ST_IDLE) && s_valid;
        cmd.exec      = (state_reg == ST_EXEC);
        cmd.div_start = (state_reg == ST_EXEC) && status.need_div;
        cmd.out_load  = (state_reg == ST_DONE) && slot_free;
        state_next    = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = status.need_div ? ST_DIV : ST_DONE;
            ST_DIV:  if (status.div_done) state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // The divider is never left running once the word is done
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !status.div_busy)
        else $error("divider busy while controller idle");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // Division completes only while the controller waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside division state");

    // An accepted word is applied on the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

endmodule

// ----- src/midi_clock_position_counter_unit.sv -----
// Top level of the MIDI clock and song position counter.
//
// Input channel (s_): one transport event word per handshake, an opcode
// (clock, start, stop, continue, internal start/stop, toggle) and the 16-bit
// timer stamp taken at the event. Output channel (m_): one result word per
// event with the forward byte and port mask, all position counters, the
// transport state, the beat LED and the measured tempo, all after the event.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index at once.
// Timing: an event word is captured on acceptance, applied in the execute
// state and loaded into the result register in the done state. Every sixth
// tick event (clock or continue) measures tempo through a serial divider, one
// quotient bit per cycle, in the division state between execute and done.
// One word is worked on at a time; s_ready is high only when the controller
// is idle.
// A result waits in the output register while m_ready is low; the next word
// may be accepted and worked on meanwhile, and its result is held back
// until the waiting word is taken.
// Reset (aresetn low, synchronous): transport paused, positions zero,
// one-based counters at 1, tempo 1920 (120 bpm), configuration cleared.
module midi_clock_position_counter_unit #(
    parameter int unsigned BAR_LIMIT = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [15:0] s_timestamp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_forward_byte,
    output logic [1:0]  m_forward_mask,
    output logic [18:0] m_pos_192,
    output logic [18:0] m_pos_96,
    output logic [16:0] m_pos_32,
    output logic [15:0] m_pos_16,
    output logic [2:0]  m_step_in_beat,
    output logic [2:0]  m_beat_in_bar,
    output logic [6:0]  m_bar_number,
    output logic [1:0]  m_transport,
    output logic        m_beat_led,
    output logic [21:0] m_tempo_q4
);

    mcpc_pkg::mcpc_cmd_t    cmd;
    mcpc_pkg::mcpc_status_t status;

    mcpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcpc_datapath #(
        .BAR_LIMIT (BAR_LIMIT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_opcode       (s_opcode),
        .s_timestamp    (s_timestamp),
        .m_forward_byte (m_forward_byte),
        .m_forward_mask (m_forward_mask),
        .m_pos_192      (m_pos_192),
        .m_pos_96       (m_pos_96),
        .m_pos_32       (m_pos_32),
        .m_pos_16       (m_pos_16),
        .m_step_in_beat (m_step_in_beat),
        .m_beat_in_bar  (m_beat_in_bar),
        .m_bar_number   (m_bar_number),
        .m_transport    (m_transport),
        .m_beat_led     (m_beat_led),
        .m_tempo_q4     (m_tempo_q4)
    );

endmodule

// ----- tb/transport_checker.sv -----
// Checker for the MIDI clock position counter: predicts each result word and compares it.
`timescale 1ns / 100ps

module transport_checker #(
    parameter int unsigned BAR_LIMIT = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [15:0] s_timestamp,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_forward_byte,
    input  logic [1:0]  m_forward_mask,
    input  logic [18:0] m_pos_192,
    input  logic [18:0] m_pos_96,
    input  logic [16:0] m_pos_32,
    input  logic [15:0] m_pos_16,
    input  logic [2:0]  m_step_in_beat,
    input  logic [2:0]  m_beat_in_bar,
    input  logic [6:0]  m_bar_number,
    input  logic [1:0]  m_transport,
    input  logic        m_beat_led,
    input  logic [21:0] m_tempo_q4,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [7:0]           fwd_byte;
        logic [1:0]           fwd_mask;
        logic [18:0]          p192;
        logic [18:0]          p96;
        logic [16:0]          p32;
        logic [15:0]          p16;
        logic [2:0]           step;
        logic [2:0]           beat;
        logic [6:0]           bar;
        mcpc_pkg::transport_t tr;
        logic                 led;
        logic [21:0]          tempo;
    } position_word_t;

    // Predicted block state
    mcpc_pkg::transport_t tr_state;
    logic [18:0] c192, c96;
    logic [16:0] c32;
    logic [15:0] c16;
    logic [2:0]  phase6, step_n, beat_n;
    logic [6:0]  bar_n;
    logic [2:0]  tick6;
    logic [15:0] prev_stamp;
    logic [21:0] tempo;
    logic        led;
    logic        mode_int, port_a, port_b;

    position_word_t expected_words[$];
    position_word_t want;
    int errs = 0;

    function automatic void clear_positions();
        tr_state = mcpc_pkg::TR_PAUSED;
        c192 = '0;
        c96 = '0;
        c32 = '0;
        c16 = '0;
        phase6 = '0;
        step_n = 3'd1;
        beat_n = 3'd1;
        bar_n = 7'd1;
    endfunction

    // One tick: tempo measurement every sixth, then the position cascade
    function automatic void count_tick(input logic [15:0] stamp);
        logic [15:0] diff;
        int unsigned bar_next;
        tick6 = tick6 + 3'd1;
        if (tick6 == mcpc_pkg::SIXTH_LAST) begin
            if (stamp >= prev_stamp) begin
                diff = stamp - prev_stamp;
            end else begin
                diff = stamp + 16'hFFFF - prev_stamp;  // keeps the off-by-one wrap
            end
            if (diff == 16'd0) begin
                diff = 16'd1;
            end
            tempo = 22'(32'(mcpc_pkg::TEMPO_DIVIDEND) / 32'(diff));
            prev_stamp = stamp;
            tick6 = '0;
        end
        if (tr_state == mcpc_pkg::TR_STARTING) begin
            tr_state = mcpc_pkg::TR_STARTED;
        end else if (tr_state == mcpc_pkg::TR_STARTED) begin
            c96 = c96 + 19'd1;
            c192 = c192 + 19'd1;
            phase6 = phase6 + 3'd1;
            if (phase6 == mcpc_pkg::SIXTH_LAST) begin
                step_n = step_n + 3'd1;
                phase6 = '0;
                c16 = c16 + 16'd1;
                c32 = c32 + 17'd1;
                // 16th wrap restarts the finer counters
                if (c16 == 16'd0) begin
                    c32 = '0;
                    c96 = '0;
                    c192 = '0;
                end
            end else if (phase6 == mcpc_pkg::SIXTH_HALF) begin
                c32 = c32 + 17'd1;
            end
            if (step_n == mcpc_pkg::COUNT_WRAP) begin
                step_n = 3'd1;
                beat_n = beat_n + 3'd1;
            end
            if (beat_n == mcpc_pkg::COUNT_WRAP) begin
                beat_n = 3'd1;
                bar_next = int'(bar_n) + 1;
                if (bar_next > BAR_LIMIT) begin
                    bar_next = 1;
                end
                bar_n = 7'(bar_next);
            end
        end
    endfunction

    function automatic logic [7:0] internal_start();
        clear_positions();
        tr_state = mcpc_pkg::TR_STARTED;
        return mcpc_pkg::BYTE_START;
    endfunction

    // LED always goes dark; the transport only stops in internal mode
    function automatic logic [7:0] internal_stop();
        led = 1'b0;
        if (mode_int) begin
            tr_state = mcpc_pkg::TR_PAUSED;
            return mcpc_pkg::BYTE_STOP;
        end
        return mcpc_pkg::BYTE_NONE;
    endfunction

    function automatic position_word_t apply_transport_event(input logic [2:0] op,
                                                             input logic [15:0] stamp);
        position_word_t w;
        logic [7:0] fwd;
        logic [1:0] mask;
        fwd = mcpc_pkg::BYTE_NONE;
        case (op)
            mcpc_pkg::OP_CLOCK: begin
                fwd = mcpc_pkg::BYTE_CLOCK;
                count_tick(stamp);
                led = (step_n == 3'd1) && (tr_state == mcpc_pkg::TR_STARTED);
            end
            mcpc_pkg::OP_START: begin
                fwd = mcpc_pkg::BYTE_START;
                clear_positions();
                tr_state = mcpc_pkg::TR_STARTING;
            end
            mcpc_pkg::OP_STOP: begin
                fwd = mcpc_pkg::BYTE_STOP;
                tr_state = mcpc_pkg::TR_PAUSED;
            end
            mcpc_pkg::OP_CONTINUE: begin
                fwd = mcpc_pkg::BYTE_CONTINUE;
                tr_state = mcpc_pkg::TR_STARTING;
                count_tick(stamp);
            end
            mcpc_pkg::OP_INT_START: begin
                if (mode_int) begin
                    fwd = internal_start();
                end
            end
            mcpc_pkg::OP_INT_STOP: begin
                fwd = internal_stop();
            end
            mcpc_pkg::OP_TOGGLE: begin
                if (mode_int) begin
                    if (tr_state == mcpc_pkg::TR_PAUSED) begin
                        fwd = internal_start();
                    end else begin
                        fwd = internal_stop();
                    end
                end
            end
            default: begin
            end
        endcase
        mask = {port_b, port_a};
        if (fwd == mcpc_pkg::BYTE_NONE || mask == 2'd0) begin
            fwd = mcpc_pkg::BYTE_NONE;
            mask = 2'd0;
        end
        w.fwd_byte = fwd;
        w.fwd_mask = mask;
        w.p192 = c192;
        w.p96 = c96;
        w.p32 = c32;
        w.p16 = c16;
        w.step = step_n;
        w.beat = beat_n;
        w.bar = bar_n;
        w.tr = tr_state;
        w.led = led;
        w.tempo = tempo;
        return w;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            errs++;
        end
    endfunction

    // Watch both channels and the register port
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_positions();
            tick6 = '0;
            prev_stamp = '0;
            tempo = mcpc_pkg::TEMPO_RESET;
            led = 1'b0;
            mode_int = 1'b0;
            port_a = 1'b0;
            port_b = 1'b0;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mcpc_pkg::CFG_INTERNAL_MODE: mode_int = cfg_data;
                    mcpc_pkg::CFG_FORWARD_A:     port_a = cfg_data;
                    mcpc_pkg::CFG_FORWARD_B:     port_b = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no expected word waiting");
                    errs++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("forward_byte", want.fwd_byte, m_forward_byte);
                    check_field("forward_mask", want.fwd_mask, m_forward_mask);
                    check_field("pos_192", want.p192, m_pos_192);
                    check_field("pos_96", want.p96, m_pos_96);
                    check_field("pos_32", want.p32, m_pos_32);
                    check_field("pos_16", want.p16, m_pos_16);
                    check_field("step_in_beat", want.step, m_step_in_beat);
                    check_field("beat_in_bar", want.beat, m_beat_in_bar);
                    check_field("bar_number", want.bar, m_bar_number);
                    check_field("transport", want.tr, m_transport);
                    check_field("beat_led", want.led, m_beat_led);
                    check_field("tempo_q4", want.tempo, m_tempo_q4);
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(apply_transport_event(s_opcode, s_timestamp));
            end
        end
        pending <= expected_words.size();
        mismatches <= errs;
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the MIDI clock position counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam int DRAIN_CYCLES = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BAR_RUN_TICKS = 120;  // a little over one bar

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = mcpc_pkg::CFG_INTERNAL_MODE;
    logic        cfg_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = mcpc_pkg::OP_CLOCK;
    logic [15:0] s_timestamp = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [7:0]  m_forward_byte;
    logic [1:0]  m_forward_mask;
    logic [18:0] m_pos_192;
    logic [18:0] m_pos_96;
    logic [16:0] m_pos_32;
    logic [15:0] m_pos_16;
    logic [2:0]  m_step_in_beat;
    logic [2:0]  m_beat_in_bar;
    logic [6:0]  m_bar_number;
    logic [1:0]  m_transport;
    logic        m_beat_led;
    logic [21:0] m_tempo_q4;

    int          mismatches;
    int          pending;
    int          idle_cycles = 0;
    int          ready_hold = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    logic [2:0]  cur_cfg = 3'b000;   // {internal_mode, port_a, port_b}
    logic [15:0] timer = 16'd0;

    always #5 aclk = ~aclk;

    midi_clock_position_counter_unit #(.BAR_LIMIT(100)) dut (.*);

    transport_checker #(.BAR_LIMIT(100)) position_check (.*);

    // Receiver: ready held for random stretches, with long stalls now and then
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready <= 1'b1;
                    ready_hold <= $urandom_range(10, 80);
                end
                1: begin
                    m_ready <= 1'b0;
                    ready_hold <= $urandom_range(0, 3);
                end
                2: begin
                    m_ready <= 1'b1;
                    ready_hold <= $urandom_range(0, 3);
                end
                default: begin
                    m_ready <= 1'b0;
                    ready_hold <= $urandom_range(5, 30);
                end
            endcase
        end
    end

    // Watchdog on cycles where no word and no register write moves
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Timer stamps: mostly rising, sometimes repeated, sometimes anywhere
    function automatic logic [15:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            timer = 16'($urandom);
        end else if (r >= 20) begin
            timer = timer + 16'($urandom_range(1, 2500));
        end
        return timer;
    endfunction

    task automatic hold_off();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Present one event word and wait for it to be taken
    task automatic send_event(input logic [2:0] op, input logic [15:0] ts);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_timestamp <= ts;
        do @(posedge aclk); while (!s_ready);
        if (gaps_on) begin
            if (burst_left == 0) begin
                hold_off();
                repeat ($urandom_range(0, 12)) @(negedge aclk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic drain();
        hold_off();
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [2:0] bits);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= mcpc_pkg::CFG_INTERNAL_MODE;
        cfg_data <= bits[2];
        @(negedge aclk);
        cfg_index <= mcpc_pkg::CFG_FORWARD_A;
        cfg_data <= bits[1];
        @(negedge aclk);
        cfg_index <= mcpc_pkg::CFG_FORWARD_B;
        cfg_data <= bits[0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_cfg = bits;
    endtask

    // Random play: an opener, then a run mostly of ticks with stray events
    task automatic run_random(input int n_items);
        int sent;
        int run_len;
        logic [2:0] op;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = mcpc_pkg::OP_START;
                4, 5:       op = mcpc_pkg::OP_CONTINUE;
                6, 7:       op = mcpc_pkg::OP_INT_START;
                default:    op = mcpc_pkg::OP_TOGGLE;
            endcase
            run_len = $urandom_range(2, 90);
            for (int k = 0; k <= run_len; k++) begin
                if (k > 0) begin
                    op = ($urandom_range(0, 99) < 90) ? mcpc_pkg::OP_CLOCK :
                                                        3'($urandom_range(0, 7));
                end
                send_event(op, next_stamp());
                // ignored words do not count
                if (!(op == OP_UNDEFINED ||
                      (!cur_cfg[2] && (op == mcpc_pkg::OP_INT_START ||
                                       op == mcpc_pkg::OP_TOGGLE)))) begin
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [2:0] phase_cfg [5];
        phase_cfg = '{3'b111, 3'b000, 3'b101, 3'b010, 3'($urandom_range(0, 7))};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: all ports on, internal mode on
        write_config(3'b111);
        send_event(mcpc_pkg::OP_CLOCK, 16'h0000);       // tick while paused
        send_event(mcpc_pkg::OP_START, 16'h0000);
        repeat (5) send_event(mcpc_pkg::OP_CLOCK, 16'h0000);  // zero stamp difference
        send_event(mcpc_pkg::OP_STOP, 16'h8000);
        send_event(OP_UNDEFINED, 16'hFFFF);
        send_event(mcpc_pkg::OP_CONTINUE, 16'h5555);
        repeat (4) send_event(mcpc_pkg::OP_CLOCK, 16'hAAAA);
        send_event(mcpc_pkg::OP_CLOCK, 16'hFFFF);       // largest difference, slowest tempo
        send_event(mcpc_pkg::OP_INT_START, 16'h1234);
        send_event(mcpc_pkg::OP_TOGGLE, 16'h0001);      // toggle while started stops
        send_event(mcpc_pkg::OP_TOGGLE, 16'h0002);      // toggle while paused starts
        send_event(mcpc_pkg::OP_INT_STOP, 16'h0003);
        drain();

        // Directed: no ports, internal events ignored, stop still clears LED
        write_config(3'b000);
        send_event(mcpc_pkg::OP_INT_START, 16'h0004);
        send_event(mcpc_pkg::OP_TOGGLE, 16'h0005);
        send_event(mcpc_pkg::OP_START, 16'h0006);
        send_event(mcpc_pkg::OP_CLOCK, 16'h0007);
        send_event(mcpc_pkg::OP_INT_STOP, 16'h0008);
        drain();

        // Run of back-to-back ticks past the first bar line
        write_config(3'b110);
        gaps_on = 1'b0;
        send_event(mcpc_pkg::OP_START, next_stamp());
        repeat (BAR_RUN_TICKS) send_event(mcpc_pkg::OP_CLOCK, next_stamp());
        gaps_on = 1'b1;
        drain();

        // Random phases under several settings
        foreach (phase_cfg[p]) begin
            write_config(phase_cfg[p]);
            run_random(120);
            drain();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
